// File: src/r2a_pkg.sv
`timescale 1ns / 1ps

package r2a_pkg;

  localparam int VALUE_BITS  = 31;
  localparam int DIGIT_SLOTS = 31;
  localparam int RADIX_BITS  = 5;
  localparam int DIGIT_BITS  = 4;
  localparam int CHAR_BITS   = 7;

  // conversion runs until the last bit fed into cell 0 has reached the top cell
  localparam int CONV_CYCLES = VALUE_BITS + DIGIT_SLOTS - 1;
  localparam int CNT_W       = $clog2(CONV_CYCLES);
  localparam int REM_W       = $clog2(DIGIT_SLOTS + 1);

  localparam logic [RADIX_BITS-1:0] RADIX_MIN = RADIX_BITS'(2);
  localparam logic [RADIX_BITS-1:0] RADIX_MAX = RADIX_BITS'(16);

  localparam logic [CHAR_BITS-1:0]  ASCII_ZERO        = CHAR_BITS'(48);
  localparam logic [CHAR_BITS-1:0]  LETTER_OFFSET     = CHAR_BITS'(55);
  localparam logic [DIGIT_BITS-1:0] MAX_DECIMAL_DIGIT = DIGIT_BITS'(9);

  typedef enum logic [1:0] {
    CM_CLEAR,
    CM_CONVERT,
    CM_SHIFT,
    CM_HOLD
  } cell_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  function automatic logic [RADIX_BITS-1:0] clamp_radix(input logic [RADIX_BITS-1:0] r);
    logic [RADIX_BITS-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  function automatic logic [CHAR_BITS-1:0] char_of_digit(input logic [DIGIT_BITS-1:0] d);
    logic [CHAR_BITS-1:0] res;
    if (d <= MAX_DECIMAL_DIGIT) res = ASCII_ZERO + CHAR_BITS'(d);
    else res = LETTER_OFFSET + CHAR_BITS'(d);
    return res;
  endfunction

endpackage

// File: src/r2a_cell.sv
`timescale 1ns / 1ps

module r2a_cell
  import r2a_pkg::*;
(
  input  logic                  clk,
  input  cell_mode_t            mode,
  input  logic [RADIX_BITS-1:0] radix,
  input  logic                  token_in,
  input  logic                  carry_in,
  input  logic [DIGIT_BITS-1:0] digit_in,
  output logic                  token_out,
  output logic                  carry_out,
  output logic [DIGIT_BITS-1:0] digit
);

  logic [DIGIT_BITS:0]   doubled;
  logic                  ge;
  logic [DIGIT_BITS:0]   reduced;

  // digit times two plus incoming bit, folded back below the radix
  assign doubled = {digit, carry_in};
  assign ge      = doubled >= radix;
  assign reduced = ge ? (doubled - radix) : doubled;

  always_ff @(posedge clk) begin
    case (mode)
      CM_CLEAR: begin
        digit     <= '0;
        carry_out <= 1'b0;
        token_out <= 1'b0;
      end
      CM_CONVERT: begin
        token_out <= token_in;
        if (token_in) begin
          digit     <= reduced[DIGIT_BITS-1:0];
          carry_out <= ge;
        end
      end
      CM_SHIFT: begin
        digit <= digit_in;
      end
      CM_HOLD: begin
      end
      default: begin
      end
    endcase
  end

endmodule

// File: src/radix_to_ascii_converter.sv
`timescale 1ns / 1ps

// Converts a 31-bit unsigned value to ASCII digits in radix 2 to 16 (radix below 2 is
// taken as 2, above 16 as 16), most significant first, 'A'-'F' for ten to fifteen, with
// last set on the final digit; zero gives a single '0'. The value is shifted bit by bit,
// most significant first, into a row of 31 digit cells, each doubling its digit and
// passing a registered carry to the next more significant cell, so conversion time
// does not depend on the radix. The row then shifts towards the output, dropping
// leading zeros and presenting one character per cycle unless char_stall is high.
// A new item is accepted only once the last character of the previous one has been
// transferred.
module radix_to_ascii_converter
  import r2a_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [RADIX_BITS-1:0] radix,
  output logic                  char_valid,
  input  logic                  char_stall,
  output logic [CHAR_BITS-1:0]  digit_char,
  output logic                  last
);

  state_t                state, state_next;
  logic [CNT_W-1:0]      cnt, cnt_next;
  logic [REM_W-1:0]      rem, rem_next;
  logic                  started, started_next;
  logic [VALUE_BITS-1:0] shreg, shreg_next;
  logic [RADIX_BITS-1:0] radix_q, radix_q_next;

  cell_mode_t            mode;
  logic                  skip;
  logic                  feed_token;

  logic [DIGIT_BITS-1:0] cell_digit [DIGIT_SLOTS];
  logic                  cell_carry [DIGIT_SLOTS];
  logic                  cell_token [DIGIT_SLOTS];
  logic [DIGIT_BITS-1:0] top_digit;

  assign top_digit = cell_digit[DIGIT_SLOTS-1];

  r2a_cell u_cell_0 (
    .clk       (clk),
    .mode      (mode),
    .radix     (radix_q),
    .token_in  (feed_token),
    .carry_in  (shreg[VALUE_BITS-1]),
    .digit_in  ('0),
    .token_out (cell_token[0]),
    .carry_out (cell_carry[0]),
    .digit     (cell_digit[0])
  );

  for (genvar i = 1; i < DIGIT_SLOTS; i++) begin : g_cell
    r2a_cell u_cell (
      .clk       (clk),
      .mode      (mode),
      .radix     (radix_q),
      .token_in  (cell_token[i-1]),
      .carry_in  (cell_carry[i-1]),
      .digit_in  (cell_digit[i-1]),
      .token_out (cell_token[i]),
      .carry_out (cell_carry[i]),
      .digit     (cell_digit[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cnt     <= '0;
      rem     <= '0;
      started <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      rem     <= rem_next;
      started <= started_next;
    end
    shreg   <= shreg_next;
    radix_q <= radix_q_next;
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    rem_next     = rem;
    started_next = started;
    shreg_next   = shreg;
    radix_q_next = radix_q;
    item_stall   = 1'b1;
    char_valid   = 1'b0;
    skip         = 1'b0;
    feed_token   = 1'b0;
    mode         = CM_HOLD;
    case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        mode       = CM_CLEAR;
        if (item_valid) begin
          shreg_next   = value;
          radix_q_next = clamp_radix(radix);
          cnt_next     = '0;
          state_next   = ST_CONV;
        end
      end
      ST_CONV: begin
        mode       = CM_CONVERT;
        feed_token = cnt < CNT_W'(VALUE_BITS);
        shreg_next = {shreg[VALUE_BITS-2:0], 1'b0};
        cnt_next   = cnt + 1'b1;
        if (cnt == CNT_W'(CONV_CYCLES - 1)) begin
          rem_next     = REM_W'(DIGIT_SLOTS);
          started_next = 1'b0;
          state_next   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // leading zeros are dropped, but the final digit always goes out
        skip       = !started && (top_digit == '0) && (rem != REM_W'(1));
        char_valid = !skip;
        if (skip || !char_stall) begin
          mode         = CM_SHIFT;
          rem_next     = rem - 1'b1;
          started_next = 1'b1;
          if (rem == REM_W'(1)) state_next = ST_IDLE;
        end
        if (skip) started_next = 1'b0;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign digit_char = char_of_digit(top_digit);
  assign last       = (rem == REM_W'(1));

  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> state == ST_CONV && cnt == '0)
    else $error("accepted item did not start conversion");

  assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_stall && last |=> state == ST_IDLE && !char_valid)
    else $error("characters continue after the last transfer");

  assert property (@(posedge clk) disable iff (rst)
    char_valid && !started && !last |-> digit_char != ASCII_ZERO)
    else $error("leading zero emitted");

  assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> rem != '0)
    else $error("digit count ran out during emission");

endmodule
